>>> sv/tmwf_pkg.sv
// tmwf_pkg: shared constants, widths, state encoding and control struct
// for the trimmed mean window filter. No dependencies.
package tmwf_pkg;

    // item and window sizes
    localparam int CODE_W     = 24;
    localparam int MAX_WINDOW = 128;
    localparam int MIN_WINDOW = 3;
    localparam int TRIM_COUNT = 2;

    // window length register
    localparam int              WLEN_W    = 8;
    localparam logic [WLEN_W-1:0] WIN_RESET = WLEN_W'(10);

    // derived widths
    localparam int SUM_W = CODE_W + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW);
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int DIV_W = $clog2(MAX_WINDOW - 1);
    localparam int BIT_W = $clog2(SUM_W);

    // register port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int WIDX_W = ADDR_W - 2;
    localparam logic [WIDX_W-1:0] REG_WINDOW = WIDX_W'(0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic load;    // capture new sample, start accumulate pass
        logic acc;     // serial add and compare pass
        logic trim;    // serial subtract of max and min
        logic div;     // restoring divide, one quotient bit a cycle
        logic bit_lo;  // current bit lies inside the code width
        logic last;    // final bit of a pass
        logic first;   // sample is the first of its window
        logic clear;   // result taken, reset window state
    } dp_ctrl_t;

endpackage

>>> sv/tmwf_cfg.sv
// tmwf_cfg: register port holding the window length, with range clamp
// and divisor derivation. Depends on tmwf_pkg.
module tmwf_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmwf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tmwf_pkg::DATA_W-1:0]  pwdata,
    output logic [tmwf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [tmwf_pkg::NW-1:0]      n_eff,
    output logic [tmwf_pkg::DIV_W-1:0]   divisor
);
    import tmwf_pkg::*;

    logic [WLEN_W-1:0] win_reg;
    logic [WLEN_W-1:0] win_next;
    logic              wr_en;
    logic [WIDX_W-1:0] widx;

    assign pready = 1'b1;
    assign widx   = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        win_next = win_reg;
        if (wr_en && (widx == REG_WINDOW))
        begin
            win_next = pwdata[WLEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_RESET;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_WINDOW: prdata = DATA_W'(win_reg);
            default:    prdata = '0;
        endcase
    end

    // values outside three to max window act as the nearest bound
    always_comb
    begin
        if (32'(win_reg) < MIN_WINDOW)
        begin
            n_eff = NW'(MIN_WINDOW);
        end
        else if (32'(win_reg) > MAX_WINDOW)
        begin
            n_eff = NW'(MAX_WINDOW);
        end
        else
        begin
            n_eff = NW'(win_reg);
        end
    end

    assign divisor = DIV_W'(n_eff - NW'(TRIM_COUNT));

endmodule

>>> sv/tmwf_dp.sv
// tmwf_dp: bit-serial datapath; sum shifts one bit a cycle (add, trim,
// divide), max and min rotate for compare and trim. Depends on tmwf_pkg.
module tmwf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmwf_pkg::dp_ctrl_t           ctl,
    input  logic [tmwf_pkg::CODE_W-1:0]  sample_code,
    input  logic [tmwf_pkg::DIV_W-1:0]   divisor,
    output logic [tmwf_pkg::CODE_W-1:0]  result
);
    import tmwf_pkg::*;

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CODE_W-1:0] smp_reg, smp_next;
    logic [CODE_W-1:0] max_reg, max_next;
    logic [CODE_W-1:0] min_reg, min_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [1:0]        cy_reg, cy_next;
    logic              gt_reg, gt_next;
    logic              lt_reg, lt_next;

    logic              s_bit, a_bit, m_bit, n_bit, d_bit;
    logic [2:0]        sub3, brw3;
    logic [DIV_W:0]    cand, cand_sub;
    logic              q_bit;

    always_comb
    begin
        s_bit = sum_reg[0];
        a_bit = ctl.bit_lo & smp_reg[0];
        m_bit = ctl.bit_lo & max_reg[0];
        n_bit = ctl.bit_lo & min_reg[0];

        // trim: sum minus max minus min, borrow up to two
        sub3  = 3'(m_bit) + 3'(n_bit) + 3'(cy_reg);
        brw3  = sub3 + 3'(s_bit ^ sub3[0]) - 3'(s_bit);

        // restoring divide step
        cand     = {rem_reg, sum_reg[SUM_W-1]};
        cand_sub = cand - (DIV_W+1)'(divisor);
        q_bit    = (cand >= (DIV_W+1)'(divisor));

        sum_next = sum_reg;
        smp_next = smp_reg;
        max_next = max_reg;
        min_next = min_reg;
        rem_next = rem_reg;
        cy_next  = cy_reg;
        gt_next  = gt_reg;
        lt_next  = lt_reg;
        d_bit    = 1'b0;

        if (ctl.load)
        begin
            smp_next = sample_code;
            cy_next  = '0;
            gt_next  = 1'b0;
            lt_next  = 1'b0;
        end
        else if (ctl.acc)
        begin
            d_bit    = s_bit ^ a_bit ^ cy_reg[0];
            cy_next  = {1'b0, (s_bit & a_bit) | (cy_reg[0] & (s_bit ^ a_bit))};
            sum_next = {d_bit, sum_reg[SUM_W-1:1]};
            if (ctl.bit_lo)
            begin
                // lsb-first magnitude compare against max and min
                gt_next  = (a_bit & ~max_reg[0]) | (~(a_bit ^ max_reg[0]) & gt_reg);
                lt_next  = (~a_bit & min_reg[0]) | (~(a_bit ^ min_reg[0]) & lt_reg);
                smp_next = {smp_reg[0], smp_reg[CODE_W-1:1]};
                max_next = {max_reg[0], max_reg[CODE_W-1:1]};
                min_next = {min_reg[0], min_reg[CODE_W-1:1]};
            end
            if (ctl.last)
            begin
                cy_next = '0;
                if (ctl.first || gt_reg)
                begin
                    max_next = smp_reg;
                end
                if (ctl.first || lt_reg)
                begin
                    min_next = smp_reg;
                end
            end
        end
        else if (ctl.trim)
        begin
            d_bit    = s_bit ^ sub3[0];
            cy_next  = brw3[2:1];
            sum_next = {d_bit, sum_reg[SUM_W-1:1]};
            if (ctl.bit_lo)
            begin
                max_next = {max_reg[0], max_reg[CODE_W-1:1]};
                min_next = {min_reg[0], min_reg[CODE_W-1:1]};
            end
            if (ctl.last)
            begin
                cy_next  = '0;
                rem_next = '0;
            end
        end
        else if (ctl.div)
        begin
            rem_next = q_bit ? cand_sub[DIV_W-1:0] : cand[DIV_W-1:0];
            sum_next = {sum_reg[SUM_W-2:0], q_bit};
        end
        else if (ctl.clear)
        begin
            sum_next = '0;
            max_next = '0;
            min_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            max_reg <= '0;
            min_reg <= '0;
            cy_reg  <= '0;
            gt_reg  <= 1'b0;
            lt_reg  <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            max_reg <= max_next;
            min_reg <= min_next;
            cy_reg  <= cy_next;
            gt_reg  <= gt_next;
            lt_reg  <= lt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        rem_reg <= rem_next;
    end

    // quotient fits the code width if the window length holds for the whole window
    assign result = sum_reg[CODE_W-1:0];

endmodule

>>> sv/tmwf_ctrl.sv
// tmwf_ctrl: sequencer with bit counter and window sample count; drives
// the serial datapath passes. Depends on tmwf_pkg.
module tmwf_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     out_free,
    input  logic [tmwf_pkg::NW-1:0]  n_eff,
    output tmwf_pkg::dp_ctrl_t       ctl
);
    import tmwf_pkg::*;

    state_t            state_reg, state_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_bit;
    logic              win_end;

    assign last_bit = (bit_reg == BIT_W'(SUM_W - 1));
    assign win_end  = ((NW'(cnt_reg) + NW'(1)) >= n_eff);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (last_bit)
                begin
                    state_next = win_end ? ST_TRIM : ST_IDLE;
                end
            end
            ST_TRIM:
            begin
                if (last_bit)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (last_bit)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        if ((state_reg == ST_ACC) || (state_reg == ST_TRIM) || (state_reg == ST_DIV))
        begin
            bit_next = last_bit ? '0 : bit_reg + BIT_W'(1);
        end
        if ((state_reg == ST_ACC) && last_bit)
        begin
            cnt_next = win_end ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    // outputs
    always_comb
    begin
        ctl        = '0;
        in_ready   = 1'b0;
        ctl.bit_lo = (32'(bit_reg) < CODE_W);
        ctl.last   = last_bit;
        ctl.first  = (cnt_reg == '0);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_ACC:  ctl.acc   = 1'b1;
            ST_TRIM: ctl.trim  = 1'b1;
            ST_DIV:  ctl.div   = 1'b1;
            ST_OUT:  ctl.clear = out_free;
            default: ctl.load  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_ACC) && (bit_reg == '0))
        else $error("accepted item did not start the accumulate pass");

    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bit_reg) < SUM_W)
        else $error("bit counter beyond sum width");

    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT) |-> ($past(state_reg) == ST_DIV))
        else $error("result phase entered without a divide");

    a_clear_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> (out_free && (state_reg == ST_OUT)))
        else $error("window cleared while output register busy");

endmodule

>>> sv/trimmed_mean_window_filter.sv
// trimmed_mean_window_filter: top level; stream ports, register port and
// output register around tmwf_cfg, tmwf_ctrl and tmwf_dp. Depends on tmwf_pkg.
//
// Groups unsigned 24-bit codes into windows of N samples (register 0 at byte
// address 0, reset 10, values below 3 act as 3 and above 128 as 128) and
// emits (sum - largest - smallest) / (N - 2), truncated, on the sample that
// closes each window. Everything runs bit-serially over the 31-bit sum word:
// an item that does not close its window is accepted and then passes through
// one serial add-and-compare pass. The closing item adds a serial trim pass, a
// restoring divide and a step that moves the quotient into the output
// register, plus any wait while an earlier result still sits unread in the
// output register. The input is taken only between items; a finished result
// may wait on the output while the next window already fills. There is no
// clearing pass after reset.
module trimmed_mean_window_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // [23:0] sample_code
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [23:0] trimmed_mean
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tmwf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tmwf_pkg::DATA_W-1:0]  pwdata,
    output logic [tmwf_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import tmwf_pkg::*;

    logic [NW-1:0]     n_eff;
    logic [DIV_W-1:0]  divisor;
    dp_ctrl_t          ctl;
    logic [CODE_W-1:0] result;
    logic              out_free;

    // output register keeps the last result while the next window runs
    logic              ovld_reg, ovld_next;
    logic [CODE_W-1:0] odata_reg, odata_next;

    tmwf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .n_eff   (n_eff),
        .divisor (divisor)
    );

    tmwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .n_eff    (n_eff),
        .ctl      (ctl)
    );

    tmwf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sample_code (s_tdata[CODE_W-1:0]),
        .divisor     (divisor),
        .result      (result)
    );

    // free when empty or being drained this cycle
    assign out_free = !ovld_reg || m_tready;

    always_comb
    begin
        ovld_next  = ovld_reg;
        odata_next = odata_reg;
        if (ovld_reg && m_tready)
        begin
            ovld_next = 1'b0;
        end
        if (ctl.clear)
        begin
            ovld_next  = 1'b1;
            odata_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = odata_reg;

endmodule
